// File: hw/rtl/gcq_pkg.sv
// Shared types and constants for the group CPU quota throttle.
// Used by every module of the block; depends on nothing.
package gcq_pkg;

    localparam int GROUP_COUNT = 8;
    localparam int GW = 3;
    localparam int CHAIN_DEPTH_DEF = 8;
    localparam logic [31:0] DEFAULT_PERIOD_DEF = 32'd100000;
    localparam int DIV_W = 40;
    localparam logic [6:0] PCT_SCALE = 7'd100;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_DECIDE = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    typedef struct packed {
        logic [1:0]    opcode;
        logic [GW-1:0] group_index;
        logic [GW-1:0] parent_index;
        logic          has_parent;
        logic          enable;
        logic [31:0]   period;
        logic [31:0]   time_limit;
        logic [31:0]   timestamp;
    } t_req;

    typedef struct packed {
        logic        may_run;
        logic [6:0]  usage_percent;
        logic [31:0] elapsed;
        logic [31:0] period_count;
        logic [31:0] throttle_count;
        logic [63:0] throttled_time;
        logic [63:0] total_time;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic frame_div;
        logic frame_latch;
        logic mul;
        logic pct_div;
        logic roll;
        logic quota;
        logic charge;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic roll_due;
        logic chain_last;
    } t_sts;

endpackage

// File: hw/rtl/gcq_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on gcq_pkg.
module gcq_div import gcq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [31:0]      i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);
    localparam int CW = $clog2(DIV_W + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [31:0]      r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [31:0]      r_dvs;
    logic [32:0]      rem_sh;
    logic [32:0]      diff;
    logic             ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = rem_sh >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[31:0] : rem_sh[31:0];
                r_quo <= {r_quo[DIV_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// File: hw/rtl/gcq_dp.sv
// Datapath: group table, chain pointer, divider, multiplier and result register.
// Depends on gcq_pkg and gcq_div.
module gcq_dp import gcq_pkg::*; #(
    parameter int          CHAIN_DEPTH    = CHAIN_DEPTH_DEF,
    parameter logic [31:0] DEFAULT_PERIOD = DEFAULT_PERIOD_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_rsp o_rsp
);
    localparam int NW = $clog2(CHAIN_DEPTH + 1);

    logic [GW-1:0] r_par  [GROUP_COUNT];
    logic          r_pv   [GROUP_COUNT];
    logic          r_en   [GROUP_COUNT];
    logic [31:0]   r_per  [GROUP_COUNT];
    logic [31:0]   r_lim  [GROUP_COUNT];
    logic [63:0]   r_run  [GROUP_COUNT];
    logic [31:0]   r_use  [GROUP_COUNT];
    logic [31:0]   r_frm  [GROUP_COUNT];
    logic [31:0]   r_pcnt [GROUP_COUNT];
    logic [31:0]   r_tcnt [GROUP_COUNT];
    logic [63:0]   r_ttot [GROUP_COUNT];
    logic          r_thr  [GROUP_COUNT];
    logic [6:0]    r_pct  [GROUP_COUNT];

    t_req             r_item;
    logic [GW-1:0]    r_g;
    logic [GW-1:0]    r_rep;
    logic [GW-1:0]    r_running;
    logic [NW-1:0]    r_n;
    logic             r_may;
    logic [31:0]      r_elapsed;
    logic [31:0]      r_start;
    logic [31:0]      r_cur;
    logic [31:0]      r_frame;
    logic [DIV_W-1:0] r_prod;
    t_rsp             r_rsp;

    logic             div_done;
    logic [DIV_W-1:0] div_q;
    logic [31:0]      use_g;
    logic [31:0]      per_g;
    logic [31:0]      cur;
    logic [32:0]      sum;

    gcq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.frame_div | i_cmd.pct_div),
        .i_dividend (i_cmd.pct_div ? r_prod : {{(DIV_W-32){1'b0}}, r_item.timestamp}),
        .i_divisor  (r_per[r_g]),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        use_g = r_use[r_g];
        per_g = r_per[r_g];
        cur   = (use_g > per_g) ? per_g : use_g;
        sum   = {1'b0, use_g} + {1'b0, r_elapsed};
    end

    assign o_sts.div_done   = div_done;
    assign o_sts.roll_due   = div_q[31:0] > r_frm[r_g];
    assign o_sts.chain_last = !r_pv[r_g] || (r_n == NW'(CHAIN_DEPTH - 1));
    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < GROUP_COUNT; i++) begin
                r_par[i]  <= '0;
                r_pv[i]   <= 1'b0;
                r_en[i]   <= 1'b0;
                r_per[i]  <= DEFAULT_PERIOD;
                r_lim[i]  <= '1;
                r_run[i]  <= '0;
                r_use[i]  <= '0;
                r_frm[i]  <= '0;
                r_pcnt[i] <= '0;
                r_tcnt[i] <= '0;
                r_ttot[i] <= '0;
                r_thr[i]  <= 1'b0;
                r_pct[i]  <= '0;
            end
            r_running <= '0;
            r_start   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_item    <= i_req;
                r_n       <= '0;
                r_may     <= (i_req.opcode == OP_DECIDE);
                r_elapsed <= (i_req.opcode == OP_END) ? i_req.timestamp - r_start : 32'd0;
                unique case (i_req.opcode)
                    OP_WRITE: begin
                        r_par[i_req.group_index] <= i_req.parent_index;
                        r_pv[i_req.group_index]  <= i_req.has_parent;
                        r_en[i_req.group_index]  <= i_req.enable;
                        r_per[i_req.group_index] <= (i_req.period == '0) ? 32'd1 : i_req.period;
                        r_lim[i_req.group_index] <= i_req.time_limit;
                        r_rep <= i_req.group_index;
                    end
                    OP_DECIDE: begin
                        r_running <= i_req.group_index;
                        r_g       <= i_req.group_index;
                        r_rep     <= i_req.group_index;
                    end
                    OP_START: begin
                        r_start <= i_req.timestamp;
                        r_rep   <= r_running;
                    end
                    default: begin
                        r_g   <= r_running;
                        r_rep <= r_running;
                    end
                endcase
            end
            if (i_cmd.frame_latch) begin
                r_frame <= div_q[31:0];
            end
            if (i_cmd.mul) begin
                r_cur  <= cur;
                r_prod <= {{(DIV_W-32){1'b0}}, cur} * {{(DIV_W-7){1'b0}}, PCT_SCALE};
            end
            if (i_cmd.roll) begin
                if (r_en[r_g]) begin
                    r_pcnt[r_g] <= r_pcnt[r_g] + 32'd1;
                end
                r_thr[r_g] <= 1'b0;
                r_pct[r_g] <= div_q[6:0];
                r_frm[r_g] <= r_frame;
                r_use[r_g] <= use_g - r_cur;
            end
            if (i_cmd.quota) begin
                if (r_en[r_g] && use_g > r_lim[r_g]) begin
                    r_may <= 1'b0;
                    if (!r_thr[r_g]) begin
                        r_tcnt[r_g] <= r_tcnt[r_g] + 32'd1;
                        r_ttot[r_g] <= r_ttot[r_g]
                            + {32'd0, (per_g > use_g) ? per_g - use_g : 32'd0};
                        r_thr[r_g]  <= 1'b1;
                    end
                end
            end
            if (i_cmd.charge) begin
                r_run[r_g] <= r_run[r_g] + {32'd0, r_elapsed};
                r_use[r_g] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            // advance along the chain after each visit
            if (i_cmd.quota || i_cmd.charge) begin
                r_g <= r_par[r_g];
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.report) begin
                r_rsp.may_run        <= r_may;
                r_rsp.usage_percent  <= r_pct[r_rep];
                r_rsp.elapsed        <= r_elapsed;
                r_rsp.period_count   <= r_pcnt[r_rep];
                r_rsp.throttle_count <= r_tcnt[r_rep];
                r_rsp.throttled_time <= r_ttot[r_rep];
                r_rsp.total_time     <= r_run[r_rep];
            end
        end
    end
endmodule

// File: hw/rtl/gcq_ctrl.sv
// Controller state machine: sequences one request through the datapath.
// Depends on gcq_pkg.
module gcq_ctrl import gcq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_opcode,
    input  logic       i_out_ready,
    input  t_sts       i_sts,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_FDIV, S_FWAIT, S_CHECK, S_MUL, S_PDIV, S_PWAIT,
        S_ROLL, S_QUOTA, S_CHARGE, S_REPORT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd             = '0;
        o_cmd.load        = (r_state == S_IDLE) && i_in_valid;
        o_cmd.frame_div   = (r_state == S_FDIV);
        o_cmd.frame_latch = (r_state == S_CHECK);
        o_cmd.mul         = (r_state == S_MUL);
        o_cmd.pct_div     = (r_state == S_PDIV);
        o_cmd.roll        = (r_state == S_ROLL);
        o_cmd.quota       = (r_state == S_QUOTA);
        o_cmd.charge      = (r_state == S_CHARGE);
        o_cmd.report      = (r_state == S_REPORT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready && !o_cmd.report) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        unique case (i_opcode)
                            OP_DECIDE: r_state <= S_FDIV;
                            OP_END:    r_state <= S_CHARGE;
                            default:   r_state <= S_REPORT;
                        endcase
                    end
                end
                S_FDIV:  r_state <= S_FWAIT;
                S_FWAIT: begin
                    if (i_sts.div_done) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: r_state <= i_sts.roll_due ? S_MUL : S_QUOTA;
                S_MUL:   r_state <= S_PDIV;
                S_PDIV:  r_state <= S_PWAIT;
                S_PWAIT: begin
                    if (i_sts.div_done) begin
                        r_state <= S_ROLL;
                    end
                end
                S_ROLL:  r_state <= S_QUOTA;
                S_QUOTA: r_state <= i_sts.chain_last ? S_REPORT : S_FDIV;
                S_CHARGE: begin
                    if (i_sts.chain_last) begin
                        r_state <= S_REPORT;
                    end
                end
                S_REPORT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/group_cpu_quota_throttle.sv
// Group CPU quota throttle: write, run start, run end (charging each level of the chain in
// turn) and decide (a frame divide per chain level, plus a percent divide when the frame
// rolls, both on the shared bit-serial divider).
// One request at a time; the next is taken once the result is in the output register.
// Reset (synchronous, active low) restores default settings and clears all statistics.
module group_cpu_quota_throttle import gcq_pkg::*; #(
    parameter int          CHAIN_DEPTH    = CHAIN_DEPTH_DEF,
    parameter logic [31:0] DEFAULT_PERIOD = DEFAULT_PERIOD_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_rsp
);
    t_cmd cmd;
    t_sts sts;

    gcq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in_req.opcode),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    gcq_dp #(
        .CHAIN_DEPTH    (CHAIN_DEPTH),
        .DEFAULT_PERIOD (DEFAULT_PERIOD)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_out_rsp)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another is in progress");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_rsp.usage_percent <= PCT_SCALE)
        else $error("usage percent above 100");

    a_may_no_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.may_run |-> o_out_rsp.elapsed == 32'd0)
        else $error("decide result carries elapsed time");
endmodule

// File: tb/group_cpu_quota_throttle_tb.sv
// Testbench for the group CPU quota throttle: drives random and directed
// requests, predicts every response with a local quota model. Depends on gcq_pkg and the DUT.
module group_cpu_quota_throttle_tb;
    import gcq_pkg::*;

    localparam int DEPTH = 8;
    localparam int WATCHDOG_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_req in_req;
    logic out_valid;
    logic out_ready;
    t_rsp out_rsp;

    group_cpu_quota_throttle DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_req(in_req),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_rsp(out_rsp)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model of the group table
    logic [2:0]  m_parent [GROUP_COUNT];
    logic        m_has_par [GROUP_COUNT];
    logic        m_enable [GROUP_COUNT];
    logic [31:0] m_period [GROUP_COUNT];
    logic [31:0] m_limit [GROUP_COUNT];
    logic [63:0] m_run_total [GROUP_COUNT];
    logic [31:0] m_usage [GROUP_COUNT];
    logic [31:0] m_frame [GROUP_COUNT];
    logic [31:0] m_periods [GROUP_COUNT];
    logic [31:0] m_throttles [GROUP_COUNT];
    logic [63:0] m_thr_total [GROUP_COUNT];
    logic        m_thr_flag [GROUP_COUNT];
    logic [6:0]  m_pct [GROUP_COUNT];
    logic [2:0]  m_running;
    logic [31:0] m_start;

    t_rsp expected_rsp[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;
    bit hold_off;

    function automatic void quota_reset();
        for (int g = 0; g < GROUP_COUNT; g++) begin
            m_parent[g] = '0;
            m_has_par[g] = 1'b0;
            m_enable[g] = 1'b0;
            m_period[g] = DEFAULT_PERIOD_DEF;
            m_limit[g] = '1;
            m_run_total[g] = '0;
            m_usage[g] = '0;
            m_frame[g] = '0;
            m_periods[g] = '0;
            m_throttles[g] = '0;
            m_thr_total[g] = '0;
            m_thr_flag[g] = 1'b0;
            m_pct[g] = '0;
        end
        m_running = '0;
        m_start = '0;
    endfunction

    // roll the frame when due and apply the quota; returns 1 if the group blocks the run
    function automatic bit visit_group(int g, logic [31:0] now);
        logic [31:0] per;
        logic [31:0] frame;
        logic [31:0] cur;
        logic [63:0] prod;
        per = (m_period[g] == 0) ? 32'd1 : m_period[g];
        frame = now / per;
        if (frame > m_frame[g]) begin
            cur = (m_usage[g] > per) ? per : m_usage[g];
            if (m_enable[g]) m_periods[g] = m_periods[g] + 1;
            m_thr_flag[g] = 1'b0;
            prod = 64'(cur) * 64'd100;
            m_pct[g] = 7'(prod / 64'(per));
            m_frame[g] = frame;
            m_usage[g] = m_usage[g] - cur;
        end
        if (m_enable[g] && m_usage[g] > m_limit[g]) begin
            if (!m_thr_flag[g]) begin
                m_throttles[g] = m_throttles[g] + 1;
                m_thr_total[g] = m_thr_total[g] +
                    ((per > m_usage[g]) ? 64'(per - m_usage[g]) : 64'd0);
                m_thr_flag[g] = 1'b1;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_rsp quota_predict(t_req r);
        t_rsp rsp;
        int g;
        logic [2:0] rep;
        logic [31:0] amount;
        logic [32:0] sum;
        rsp = '0;
        rep = r.group_index;
        case (r.opcode)
            OP_WRITE: begin
                m_parent[r.group_index] = r.parent_index;
                m_has_par[r.group_index] = r.has_parent;
                m_enable[r.group_index] = r.enable;
                m_period[r.group_index] = (r.period == 0) ? 32'd1 : r.period;
                m_limit[r.group_index] = r.time_limit;
            end
            OP_DECIDE: begin
                rsp.may_run = 1'b1;
                m_running = r.group_index;
                g = r.group_index;
                for (int n = 0; n < DEPTH && g < GROUP_COUNT; n++) begin
                    if (visit_group(g, r.timestamp)) rsp.may_run = 1'b0;
                    g = m_has_par[g] ? int'(m_parent[g]) : GROUP_COUNT;
                end
            end
            OP_START: begin
                m_start = r.timestamp;
                rep = m_running;
            end
            default: begin
                amount = r.timestamp - m_start;
                rsp.elapsed = amount;
                g = m_running;
                for (int n = 0; n < DEPTH && g < GROUP_COUNT; n++) begin
                    sum = 33'(m_usage[g]) + 33'(amount);
                    m_run_total[g] = m_run_total[g] + 64'(amount);
                    m_usage[g] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    g = m_has_par[g] ? int'(m_parent[g]) : GROUP_COUNT;
                end
                rep = m_running;
            end
        endcase
        rsp.usage_percent = m_pct[rep];
        rsp.period_count = m_periods[rep];
        rsp.throttle_count = m_throttles[rep];
        rsp.throttled_time = m_thr_total[rep];
        rsp.total_time = m_run_total[rep];
        return rsp;
    endfunction

    // sender: holds valid until accepted, predicts on acceptance
    task automatic send_request(t_req r);
        in_valid <= 1'b1;
        in_req <= r;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        expected_rsp.push_back(quota_predict(r));
    endtask

    int burst_left;
    task automatic pace_and_send(t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_request(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_rsp.size() != 0 && !timed_out) @(posedge i_clk);
    endtask

    function automatic t_req make_req(logic [1:0] op, logic [2:0] gi, logic [2:0] pi,
                                      logic hp, logic en, logic [31:0] per,
                                      logic [31:0] lim, logic [31:0] now);
        t_req r;
        r.opcode = op;
        r.group_index = gi;
        r.parent_index = pi;
        r.has_parent = hp;
        r.enable = en;
        r.period = per;
        r.time_limit = lim;
        r.timestamp = now;
        return r;
    endfunction

    function automatic t_req random_req(logic [31:0] now);
        t_req r;
        r = make_req(2'($urandom_range(0, 3)), 3'($urandom), 3'($urandom), 1'($urandom),
                     1'($urandom), $urandom_range(50, 2000), $urandom_range(0, 1500), now);
        if ($urandom_range(0, 15) == 0) r.period = $urandom;
        if ($urandom_range(0, 15) == 0) r.time_limit = $urandom;
        if ($urandom_range(0, 31) == 0) r.period = '0;
        if ($urandom_range(0, 15) == 0) r.timestamp = $urandom;
        return r;
    endfunction

    // response checker
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %p", out_rsp);
            end else begin
                exp_rsp = expected_rsp.pop_front();
                if (out_rsp !== exp_rsp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_rsp, out_rsp);
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    int stall_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (hold_off) out_ready <= 1'b0;
            else if (stall_phase % 400 < 150) out_ready <= 1'b1;
            else out_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(make_req(OP_DECIDE, 3'd0, 3'd0, 1'b0, 1'b0, 0, 0, 32'd0));
        send_request(make_req(OP_WRITE, 3'd7, 3'd0, 1'b1, 1'b1, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'd0));
        send_request(make_req(OP_WRITE, 3'd0, 3'd1, 1'b1, 1'b1, 32'd1000, 32'd100, 0));
        send_request(make_req(OP_WRITE, 3'd1, 3'd2, 1'b1, 1'b1, 32'd0, 32'd0, 0));
        send_request(make_req(OP_WRITE, 3'd2, 3'd0, 1'b1, 1'b1, 32'd500, 32'd0, 0));
        send_request(make_req(OP_DECIDE, 3'd0, 3'd7, 1'b1, 1'b1, 0, 0, 32'd10));
        send_request(make_req(OP_START, 3'd5, 3'd6, 1'b1, 1'b1, 0, 0, 32'd100));
        send_request(make_req(OP_END, 3'd0, 3'd0, 1'b0, 1'b0, 0, 0, 32'd900));
        send_request(make_req(OP_END, 3'd0, 3'd0, 1'b0, 1'b0, 0, 0, 32'd50));
        send_request(make_req(OP_DECIDE, 3'd0, 3'd0, 1'b0, 1'b0, 0, 0, 32'd1500));
        send_request(make_req(OP_DECIDE, 3'd0, 3'd0, 1'b0, 1'b0, 0, 0, 32'd1600));
        send_request(make_req(OP_DECIDE, 3'd0, 3'd0, 1'b0, 1'b0, 0, 0, 32'hFFFF_FFFF));
        send_request(make_req(OP_START, 3'd0, 3'd0, 1'b0, 1'b0, 0, 0, 32'hFFFF_FFFF));
        send_request(make_req(OP_END, 3'd0, 3'd0, 1'b0, 1'b0, 0, 0, 32'hFFFF_FFFE));
        send_request(make_req(OP_DECIDE, 3'd7, 3'd0, 1'b0, 1'b0, 0, 0, 32'd0));
        send_request(make_req(OP_WRITE, 3'd3, 3'd7, 1'b0, 1'b0, 32'd1, 32'd0, 32'd5));
        send_request(make_req(OP_DECIDE, 3'd3, 3'd0, 1'b0, 1'b0, 0, 0, 32'd7));
        drain();
    endtask

    task automatic test_random();
        logic [31:0] now;
        t_req r;
        now = 32'd2000;
        for (int i = 0; i < 540; i++) begin
            now = now + $urandom_range(0, 900);
            // mostly decide/start/end cycles with random content
            if ($urandom_range(0, 3) != 0 && i % 5 != 0) begin
                pace_and_send(make_req(OP_DECIDE, 3'($urandom), 3'($urandom), 1'($urandom),
                                       1'($urandom), $urandom, $urandom, now));
                pace_and_send(make_req(OP_START, 3'($urandom), 3'($urandom), 1'($urandom),
                                       1'($urandom), $urandom, $urandom, now));
                now = now + $urandom_range(0, 1200);
                r = random_req(now);
                r.opcode = OP_END;
                pace_and_send(r);
                i += 2;
            end else begin
                pace_and_send(random_req(now));
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 40; i++) send_request(random_req(32'(i * 37)));
        join
        drain();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_req <= '0;
        hold_off = 1'b0;
        burst_left = 0;
        quota_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        repeat (1000) @(posedge i_clk);
        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
